### rtl/skm_pkg.sv
// Shared types, constants and state encoding for the scalar Kalman filter bank.
package skm_pkg;

    localparam int NUM_AXES_DEF = 9;
    localparam int AXIS_W       = 4;
    localparam int DATA_W       = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int GAIN_W       = 16;
    localparam int QUOT_W       = GAIN_W + 1;
    localparam int DIV_CNT_W    = 5;

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = 32'd66;
    localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = 32'd6554;

    localparam logic REG_PROCESS_NOISE     = 1'b0;
    localparam logic REG_MEASUREMENT_NOISE = 1'b1;

    typedef struct packed {
        logic        [AXIS_W-1:0] axis;
        logic signed [DATA_W-1:0] measurement;
    } in_t;

    typedef struct packed {
        logic        [AXIS_W-1:0] axis_out;
        logic signed [DATA_W-1:0] estimate;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MULP,
        ST_MULX,
        ST_DONE
    } state_t;

endpackage

### rtl/scalar_kalman_multi_axis.sv
// Top level of the multi-axis scalar Kalman filter bank.
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries an axis number and a
//   signed Q16.16 measurement; an item is taken when in_valid is high and
//   in_stall is low. Output channel out_valid/out_stall/out_item returns the
//   axis and its updated estimate, one result per input item.
//   Q and R are written over the APB port (Q at 0x0, R at 0x4) while idle.
//   Items are taken one at a time: in_stall stays high from accept until the
//   result is handed to the output register. The gain divider is a restoring
//   divider producing one quotient bit per cycle, followed by ST_MULP, ST_MULX
//   and a write-back to the state RAMs in ST_DONE.
//   An axis at or above NUM_AXES changes no state and returns estimate 0.
//   A finished result waits in the output register while out_stall is high;
//   the next item is accepted meanwhile, and its write-back waits until the
//   output register is free.
//   Reset clears every axis (estimate and covariance read as zero through
//   per-axis valid bits) and restores Q and R to their defaults.
module scalar_kalman_multi_axis #(
    parameter int NUM_AXES = skm_pkg::NUM_AXES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  skm_pkg::in_t                      in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output skm_pkg::out_t                     out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [skm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [skm_pkg::DATA_W-1:0]        pwdata,
    output logic [skm_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    import skm_pkg::*;

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    state_t state_reg, state_next;

    logic [DATA_W-1:0]      q_noise_reg;
    logic [DATA_W-1:0]      r_noise_reg;
    logic [NUM_AXES-1:0]    vld_reg;
    logic                   out_valid_reg;
    out_t                   out_item_reg;

    logic [AXIS_W-1:0]      axis_reg;
    logic signed [DATA_W-1:0] z_reg;
    logic                   in_range_reg;
    logic [DATA_W-1:0]      p_reg;
    logic [DATA_W:0]        den_reg;
    logic [DATA_W+1:0]      rem_reg;
    logic [QUOT_W-1:0]      quot_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic signed [DATA_W:0] diff_reg;
    logic [DATA_W-1:0]      cov_new_reg;
    logic signed [DATA_W-1:0] est_new_reg;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   out_free;
    logic                   wb_en;
    logic                   div_last;
    logic                   in_range_in;
    logic [AW-1:0]          raddr;
    logic [AW-1:0]          waddr;
    logic [DATA_W-1:0]      est_rdata;
    logic [DATA_W-1:0]      cov_rdata;
    logic [DATA_W-1:0]      est_cur;
    logic [DATA_W-1:0]      cov_cur;
    logic [DATA_W:0]        p_sum;
    logic [DATA_W-1:0]      p_sat;
    logic [DATA_W:0]        den_sum;
    logic [DATA_W+1:0]      trial;
    logic                   qbit;
    logic [GAIN_W-1:0]      gain_val;
    logic [2*DATA_W-1:0]    cov_prod;
    logic signed [GAIN_W+DATA_W+1:0] est_prod;
    logic signed [DATA_W+1:0] est_sum;

    assign in_accept   = in_valid && !in_stall;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign out_free    = !out_valid_reg || !out_stall;
    assign div_last    = (cnt_reg == DIV_CNT_W'(QUOT_W - 1));
    assign in_range_in = ({1'b0, in_item.axis} < (AXIS_W + 1)'(NUM_AXES));
    assign raddr       = in_item.axis[AW-1:0];
    assign waddr       = axis_reg[AW-1:0];

    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? r_noise_reg : q_noise_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = in_range_reg ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_MULP;
                end
            end
            ST_MULP:
            begin
                state_next = ST_MULX;
            end
            ST_MULX:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        wb_en    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_DONE:
            begin
                wb_en = out_free && in_range_reg;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_noise_reg <= PROCESS_NOISE_RST;
            r_noise_reg <= MEASUREMENT_NOISE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_PROCESS_NOISE:     q_noise_reg <= pwdata;
                REG_MEASUREMENT_NOISE: r_noise_reg <= pwdata;
                default:               q_noise_reg <= q_noise_reg;
            endcase
        end
    end

    skm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_AXES)
    ) u_est_ram (
        .clk   (clk),
        .we    (wb_en),
        .waddr (waddr),
        .wdata (est_new_reg),
        .raddr (raddr),
        .rdata (est_rdata)
    );

    skm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_AXES)
    ) u_cov_ram (
        .clk   (clk),
        .we    (wb_en),
        .waddr (waddr),
        .wdata (cov_new_reg),
        .raddr (raddr),
        .rdata (cov_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wb_en)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    assign est_cur = vld_reg[waddr] ? est_rdata : '0;
    assign cov_cur = vld_reg[waddr] ? cov_rdata : '0;
    assign p_sum   = {1'b0, cov_cur} + {1'b0, q_noise_reg};
    assign p_sat   = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
    assign den_sum = {1'b0, p_sat} + {1'b0, r_noise_reg};

    assign trial = (cnt_reg == '0) ? rem_reg : {rem_reg[DATA_W:0], 1'b0};
    assign qbit  = (trial >= {1'b0, den_reg});

    assign gain_val = (den_reg == '0)    ? '0 :
                      quot_reg[QUOT_W-1] ? '1 : quot_reg[GAIN_W-1:0];

    assign cov_prod = {{(DATA_W-GAIN_W-1){1'b0}}, ((QUOT_W)'(1) << GAIN_W) -
                       {1'b0, gain_reg}} * {{DATA_W{1'b0}}, p_reg};
    assign est_prod = $signed({1'b0, gain_reg}) * diff_reg;
    assign est_sum  = {{2{x_reg[DATA_W-1]}}, x_reg} +
                      est_prod[GAIN_W+DATA_W+1:GAIN_W];

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    axis_reg     <= in_item.axis;
                    z_reg        <= in_item.measurement;
                    in_range_reg <= in_range_in;
                end
            end
            ST_LOAD:
            begin
                x_reg   <= est_cur;
                p_reg   <= p_sat;
                den_reg <= den_sum;
                rem_reg <= {1'b0, den_sum[DATA_W] & 1'b0, p_sat};
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= qbit ? (trial - {1'b0, den_reg}) : trial;
                quot_reg <= {quot_reg[QUOT_W-2:0], qbit};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            ST_MULP:
            begin
                gain_reg <= gain_val;
                diff_reg <= {z_reg[DATA_W-1], z_reg} - {x_reg[DATA_W-1], x_reg};
            end
            ST_MULX:
            begin
                cov_new_reg <= cov_prod[GAIN_W+DATA_W-1:GAIN_W];
                est_new_reg <= est_sum[DATA_W-1:0];
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_item_reg.axis_out <= axis_reg;
            out_item_reg.estimate <= in_range_reg ? est_new_reg : '0;
        end
    end

endmodule

### rtl/skm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module skm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/skm_checker.sv
// Port-level checker for the Kalman filter bank, bound to the top level.
module skm_checker #(
    parameter int NUM_AXES = skm_pkg::NUM_AXES_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input skm_pkg::out_t out_item
);

    import skm_pkg::*;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while previous item still in work");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ({1'b0, out_item.axis_out} >= (AXIS_W + 1)'(NUM_AXES)))
        |-> (out_item.estimate == '0))
        else $error("out-of-range axis returned nonzero estimate");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_item))
        else $error("stalled result changed");

endmodule

bind scalar_kalman_multi_axis skm_checker #(
    .NUM_AXES (NUM_AXES)
) u_skm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
